// ===== src/hd_pkg.sv =====
// Shared constants and the CORDIC arctangent table for the haversine distance block.
package hd_pkg;

  localparam int HD_CORDIC_STAGES = 24;
  localparam int HD_SQRT_STEPS    = 31;

  // 3.6e9 / 1024: the power-of-two part of the divisor is taken off by shifting
  localparam logic [21:0] HD_DIV_DEN   = 22'd3515625;
  localparam logic [52:0] HD_ROUND_OFS = 53'd1757812;
  // floor(2^53 / HD_DIV_DEN): applied to the top 32 numerator bits, the
  // quotient estimate falls short by at most one
  localparam logic [31:0] HD_DIV_RECIP = 32'd2562047788;

  localparam logic signed [32:0] HD_CORDIC_X0 = 33'sd652032874;
  localparam logic [30:0] HD_HALF_PI_Q30      = 31'd1686629713;
  localparam logic [30:0] HD_ONE_Q30          = 31'h4000_0000;
  localparam logic [60:0] HD_ONE_Q60          = {1'b1, 60'd0};
  localparam logic [23:0] HD_RADIUS_RESET     = 24'd6367445;
  localparam logic [25:0] HD_DIST_MAX         = 26'h3FF_FFFF;

  // Register decode: paddr bit 2 selects the register word
  localparam logic HD_REG_RADIUS = 1'b0;

  function automatic logic signed [32:0] hd_atan(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return $signed({1'b0, v});
  endfunction

endpackage

// ===== src/hd_angle_conv.sv =====
// Coordinate to binary half-angle converter: reciprocal multiply and one correction step.
module hd_angle_conv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en_i,
  input  logic        vld_i,
  input  logic [31:0] coord_i,
  output logic        vld_o,
  output logic [31:0] angle_o
);
  import hd_pkg::*;

  logic        neg;
  logic [31:0] mag;
  logic [52:0] num_nxt;
  logic [63:0] prod_nxt;
  logic [23:0] rem_nxt;
  logic [30:0] quo_nxt;

  logic        vld1_r, vld2_r, vld3_r, vld4_r;
  logic        neg1_r, neg2_r, neg3_r, neg4_r;
  logic [52:0] num1_r;
  logic [30:0] qest2_r;
  logic [23:0] nlo2_r;
  logic [30:0] quo3_r;
  logic [23:0] rem3_r;
  logic [30:0] quo4_r;

  assign neg = coord_i[31];
  assign mag = neg ? (~coord_i + 32'd1) : coord_i;
  // floor of (mag * 2^31 + 1.8e9) / 1024, exact
  assign num_nxt = {mag, 21'd0} + HD_ROUND_OFS;
  // quotient estimate from the top 32 bits, never above the true quotient
  assign prod_nxt = 64'(num1_r[52:21]) * 64'(HD_DIV_RECIP);
  // the remainder is below twice the divisor, so its low 24 bits are exact
  assign rem_nxt = nlo2_r - 24'(qest2_r[23:0] * {2'b00, HD_DIV_DEN});
  assign quo_nxt = (rem_nxt >= {2'b00, HD_DIV_DEN}) ? 31'(quo3_r + 31'd1) : quo3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (en_i) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      neg1_r  <= neg;
      num1_r  <= num_nxt;
      neg2_r  <= neg1_r;
      qest2_r <= prod_nxt[62:32];
      nlo2_r  <= num1_r[23:0];
      neg3_r  <= neg2_r;
      quo3_r  <= qest2_r;
      rem3_r  <= rem_nxt;
      neg4_r  <= neg3_r;
      quo4_r  <= (rem3_r >= {2'b00, HD_DIV_DEN}) ? 31'(quo3_r + 31'd1) : quo3_r;
    end
  end

  assign vld_o   = vld4_r;
  assign angle_o = neg4_r ? (32'd0 - {1'b0, quo4_r}) : {1'b0, quo4_r};

endmodule

// ===== src/hd_rot_cordic.sv =====
// Rotation-mode CORDIC sine and cosine: one micro-rotation cell per stage.
module hd_rot_cordic #(
  parameter int STAGES = hd_pkg::HD_CORDIC_STAGES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [31:0]        theta_i,
  output logic               vld_o,
  output logic signed [32:0] sin_o,
  output logic signed [32:0] cos_o
);
  import hd_pkg::*;

  logic              flip;
  logic [31:0]       theta_f;

  logic              vld_r  [STAGES];
  logic              flip_r [STAGES];
  logic signed [32:0] x_r   [STAGES];
  logic signed [32:0] y_r   [STAGES];
  logic signed [32:0] z_r   [STAGES];

  // fold the second and third quadrants onto the fourth and first
  assign flip    = theta_i[31] ^ theta_i[30];
  assign theta_f = flip ? {~theta_i[31], theta_i[30:0]} : theta_i;

  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    logic               vld_in;
    logic               flip_in;
    logic signed [32:0] x_in;
    logic signed [32:0] y_in;
    logic signed [32:0] z_in;
    logic signed [32:0] dx;
    logic signed [32:0] dy;

    if (g == 0) begin : g_head
      assign vld_in  = vld_i;
      assign flip_in = flip;
      assign x_in    = HD_CORDIC_X0;
      assign y_in    = '0;
      assign z_in    = $signed({theta_f[31], theta_f});
    end else begin : g_link
      assign vld_in  = vld_r[g-1];
      assign flip_in = flip_r[g-1];
      assign x_in    = x_r[g-1];
      assign y_in    = y_r[g-1];
      assign z_in    = z_r[g-1];
    end

    assign dx = y_in >>> g;
    assign dy = x_in >>> g;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en_i) begin
        vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en_i) begin
        flip_r[g] <= flip_in;
        if (!z_in[32]) begin
          x_r[g] <= x_in - dx;
          y_r[g] <= y_in + dy;
          z_r[g] <= z_in - hd_atan(g);
        end else begin
          x_r[g] <= x_in + dx;
          y_r[g] <= y_in - dy;
          z_r[g] <= z_in + hd_atan(g);
        end
      end
    end
  end

  assign vld_o = vld_r[STAGES-1];
  assign sin_o = flip_r[STAGES-1] ? -y_r[STAGES-1] : y_r[STAGES-1];
  assign cos_o = flip_r[STAGES-1] ? -x_r[STAGES-1] : x_r[STAGES-1];

endmodule

// ===== src/hd_isqrt.sv =====
// Integer square root of a Q60 value: one digit-recurrence cell per result bit.
module hd_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en_i,
  input  logic        vld_i,
  input  logic [60:0] rad_i,
  output logic        vld_o,
  output logic [30:0] root_o
);
  import hd_pkg::*;

  localparam int STEPS = HD_SQRT_STEPS;

  logic        vld_r [STEPS];
  logic [60:0] v_r   [STEPS];
  logic [61:0] r_r   [STEPS];

  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    localparam logic [61:0] BIT = 62'd1 << (2 * (STEPS - 1 - g));
    logic        vld_in;
    logic [60:0] v_in;
    logic [61:0] r_in;
    logic [61:0] trial;

    if (g == 0) begin : g_head
      assign vld_in = vld_i;
      assign v_in   = rad_i;
      assign r_in   = '0;
    end else begin : g_link
      assign vld_in = vld_r[g-1];
      assign v_in   = v_r[g-1];
      assign r_in   = r_r[g-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en_i) begin
        vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en_i) begin
        if ({1'b0, v_in} >= trial) begin
          v_r[g] <= 61'({1'b0, v_in} - trial);
          r_r[g] <= (r_in >> 1) + BIT;
        end else begin
          v_r[g] <= v_in;
          r_r[g] <= r_in >> 1;
        end
      end
    end
  end

  assign vld_o  = vld_r[STEPS-1];
  assign root_o = r_r[STEPS-1][30:0];

endmodule

// ===== src/hd_vec_cordic.sv =====
// Vectoring-mode CORDIC angle of a vector: one micro-rotation cell per stage.
module hd_vec_cordic #(
  parameter int STAGES = hd_pkg::HD_CORDIC_STAGES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [30:0]        x_i,
  input  logic [30:0]        y_i,
  output logic               vld_o,
  output logic signed [32:0] angle_o
);
  import hd_pkg::*;

  logic               vld_r [STAGES];
  logic signed [32:0] x_r   [STAGES];
  logic signed [32:0] y_r   [STAGES];
  logic signed [32:0] z_r   [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    logic               vld_in;
    logic signed [32:0] x_in;
    logic signed [32:0] y_in;
    logic signed [32:0] z_in;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic               y_pos;

    if (g == 0) begin : g_head
      assign vld_in = vld_i;
      assign x_in   = $signed({2'b00, x_i});
      assign y_in   = $signed({2'b00, y_i});
      assign z_in   = '0;
    end else begin : g_link
      assign vld_in = vld_r[g-1];
      assign x_in   = x_r[g-1];
      assign y_in   = y_r[g-1];
      assign z_in   = z_r[g-1];
    end

    assign dx    = y_in >>> g;
    assign dy    = x_in >>> g;
    assign y_pos = !y_in[32] && (y_in != '0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en_i) begin
        vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en_i) begin
        if (y_pos) begin
          x_r[g] <= x_in + dx;
          y_r[g] <= y_in - dy;
          z_r[g] <= z_in + hd_atan(g);
        end else begin
          x_r[g] <= x_in - dx;
          y_r[g] <= y_in + dy;
          z_r[g] <= z_in - hd_atan(g);
        end
      end
    end
  end

  assign vld_o   = vld_r[STAGES-1];
  assign angle_o = z_r[STAGES-1];

endmodule

// ===== src/haversine_distance.sv =====
// Top level of the pipelined haversine great-circle distance block.
//
// Usage: present two points (latitude and longitude in 1e-7 degree) as one
// beat on the in_ channel; one beat carrying the distance in metres leaves on
// the out_ channel for every input beat, in order. The sphere radius sits in a
// single APB register at byte address 0; write it only while idle (unchecked).
//
// Throughput: one beat per cycle while the output is not stalled. The depth is
// set by the 31-cell square-root chain and by the two CORDIC chains; the angle
// converters add their reciprocal-multiply registers and the rest are
// single-stage multipliers, clamps and the output register.
//
// The whole pipeline advances on one enable. When out_valid is high and the
// receiver holds out_ready low, the enable drops: every stage holds, the
// result stays on the output register and in_ready falls. In any other cycle
// a new beat is taken, even while the previous result is being handed over.
//
// Reset (synchronous, rst_n low) clears every stage valid bit and restores the
// radius register to its default; data registers are left as they are.
module haversine_distance #(
  parameter int CORDIC_STAGES = hd_pkg::HD_CORDIC_STAGES
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [30:0] in_first_lat,
  input  logic [31:0] in_first_lon,
  input  logic [30:0] in_second_lat,
  input  logic [31:0] in_second_lon,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [25:0] out_distance_m,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import hd_pkg::*;

  logic en;
  logic in_take;

  // radius register
  logic [23:0] radius_r;
  logic        cfg_wr;

  // half angles out of the converters
  logic        cv_vld;
  logic [31:0] a_lat1, a_lon1, a_lat2, a_lon2;

  // stage 1: differences and full latitudes
  logic        vld1_r;
  logic [31:0] dlat_r, dlon_r, lat1_r, lat2_r;

  // trigonometry
  logic               tr_vld;
  logic signed [32:0] s_dlat, s_dlon, c_lat1, c_lat2;

  // stages 2 to 5: the haversine sum
  logic               vld2_r, vld3_r, vld4_r, vld5_r;
  logic signed [65:0] uprod_r, vprod_r;
  logic signed [32:0] sdlat_r;
  logic signed [65:0] uv_r, ss_r;
  logic signed [66:0] hsum;
  logic [60:0]        h_r, hh_r, hc_r;

  // square roots and arcsine
  logic               sq_vld;
  logic [30:0]        root_h, root_c;
  logic               vc_vld;
  logic signed [32:0] zang;

  // stages 6 to 10: scale to metres
  logic               vld6_r, vld7_r, vld8_r, vld9_r, out_vld_r;
  logic [30:0]        zc_r;
  logic [61:0]        radp_r;
  logic [62:0]        rad_sum;
  logic [30:0]        rad_r;
  logic [54:0]        dprod_r;
  logic [56:0]        dsum;
  logic [26:0]        dq;
  logic [25:0]        dist_r;

  // hold every stage while the finished result is refused
  assign en       = !out_vld_r || out_ready;
  assign in_ready = en;
  assign in_take  = in_valid && en;

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == HD_REG_RADIUS) ? {8'd0, radius_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= HD_RADIUS_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == HD_REG_RADIUS)) begin
      radius_r <= cfg_pwdata[23:0];
    end
  end

  // ---------------- coordinates to half angles ----------------
  hd_angle_conv u_conv_lat1 (
    .clk(clk), .rst_n(rst_n), .en_i(en), .vld_i(in_take),
    .coord_i({in_first_lat[30], in_first_lat}), .vld_o(cv_vld), .angle_o(a_lat1)
  );
  hd_angle_conv u_conv_lon1 (
    .clk(clk), .rst_n(rst_n), .en_i(en), .vld_i(in_take),
    .coord_i(in_first_lon), .vld_o(), .angle_o(a_lon1)
  );
  hd_angle_conv u_conv_lat2 (
    .clk(clk), .rst_n(rst_n), .en_i(en), .vld_i(in_take),
    .coord_i({in_second_lat[30], in_second_lat}), .vld_o(), .angle_o(a_lat2)
  );
  hd_angle_conv u_conv_lon2 (
    .clk(clk), .rst_n(rst_n), .en_i(en), .vld_i(in_take),
    .coord_i(in_second_lon), .vld_o(), .angle_o(a_lon2)
  );

  // stage 1: half differences wrap modulo a full turn; latitudes double
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= cv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dlat_r <= a_lat2 - a_lat1;
      dlon_r <= a_lon2 - a_lon1;
      lat1_r <= {a_lat1[30:0], 1'b0};
      lat2_r <= {a_lat2[30:0], 1'b0};
    end
  end

  // ---------------- sines and cosines ----------------
  hd_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_dlat (
    .clk(clk), .rst_n(rst_n), .en_i(en), .vld_i(vld1_r), .theta_i(dlat_r),
    .vld_o(tr_vld), .sin_o(s_dlat), .cos_o()
  );
  hd_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_dlon (
    .clk(clk), .rst_n(rst_n), .en_i(en), .vld_i(vld1_r), .theta_i(dlon_r),
    .vld_o(), .sin_o(s_dlon), .cos_o()
  );
  hd_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_lat1 (
    .clk(clk), .rst_n(rst_n), .en_i(en), .vld_i(vld1_r), .theta_i(lat1_r),
    .vld_o(), .sin_o(), .cos_o(c_lat1)
  );
  hd_rot_cordic #(.STAGES(CORDIC_STAGES)) u_rot_lat2 (
    .clk(clk), .rst_n(rst_n), .en_i(en), .vld_i(vld1_r), .theta_i(lat2_r),
    .vld_o(), .sin_o(), .cos_o(c_lat2)
  );

  // ---------------- haversine sum ----------------
  assign hsum = 67'(ss_r) + 67'(uv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else if (en) begin
      vld2_r <= tr_vld;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 2: cos(lat) * sin(dlon/2)
      uprod_r <= c_lat1 * s_dlon;
      vprod_r <= c_lat2 * s_dlon;
      sdlat_r <= s_dlat;
      // stage 3: drop back to Q30 by flooring, then the two Q60 terms
      uv_r <= $signed(uprod_r[62:30]) * $signed(vprod_r[62:30]);
      ss_r <= sdlat_r * sdlat_r;
      // stage 4: clamp into [0, one]
      if (hsum[66]) begin
        h_r <= '0;
      end else if (hsum > $signed({6'd0, HD_ONE_Q60})) begin
        h_r <= HD_ONE_Q60;
      end else begin
        h_r <= hsum[60:0];
      end
      // stage 5: sine and cosine squared of the half central angle
      hh_r <= h_r;
      hc_r <= HD_ONE_Q60 - h_r;
    end
  end

  // ---------------- square roots and arcsine ----------------
  hd_isqrt u_sqrt_h (
    .clk(clk), .rst_n(rst_n), .en_i(en), .vld_i(vld5_r), .rad_i(hh_r),
    .vld_o(sq_vld), .root_o(root_h)
  );
  hd_isqrt u_sqrt_c (
    .clk(clk), .rst_n(rst_n), .en_i(en), .vld_i(vld5_r), .rad_i(hc_r),
    .vld_o(), .root_o(root_c)
  );

  hd_vec_cordic #(.STAGES(CORDIC_STAGES)) u_asin (
    .clk(clk), .rst_n(rst_n), .en_i(en), .vld_i(sq_vld),
    .x_i(root_c), .y_i(root_h), .vld_o(vc_vld), .angle_o(zang)
  );

  // ---------------- scale to metres ----------------
  assign rad_sum = {1'b0, radp_r} + 63'd536870912;
  assign dsum    = {1'b0, dprod_r, 1'b0} + 57'd536870912;
  assign dq      = dsum[56:30];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld6_r    <= 1'b0;
      vld7_r    <= 1'b0;
      vld8_r    <= 1'b0;
      vld9_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld6_r    <= vc_vld;
      vld7_r    <= vld6_r;
      vld8_r    <= vld7_r;
      vld9_r    <= vld8_r;
      out_vld_r <= vld9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 6: clamp the angle into a quarter turn
      if (zang[32]) begin
        zc_r <= '0;
      end else if (zang > $signed({2'b00, HD_ONE_Q30})) begin
        zc_r <= HD_ONE_Q30;
      end else begin
        zc_r <= zang[30:0];
      end
      // stages 7 and 8: binary angle to Q30 radians, rounded
      radp_r <= zc_r * HD_HALF_PI_Q30;
      rad_r  <= rad_sum[60:30];
      // stage 9: radius times angle
      dprod_r <= radius_r * rad_r;
      // stage 10: double, round, saturate
      dist_r <= dq[26] ? HD_DIST_MAX : dq[25:0];
    end
  end

  assign out_valid      = out_vld_r;
  assign out_distance_m = dist_r;

`ifndef NO_ASSERTIONS
  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a refused result freezes the earlier stages too
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(vld9_r) && $stable(vld1_r)))
    else $error("pipeline moved while output stalled");

  // the two square-root operands always sum to one
  a_h_split: assert property (@(posedge clk) disable iff (!rst_n)
    vld5_r |-> ((62'(hh_r) + 62'(hc_r)) == 62'(HD_ONE_Q60)))
    else $error("haversine operands inconsistent");

  // the clamped angle never exceeds a quarter turn
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld6_r |-> (zc_r <= HD_ONE_Q30))
    else $error("arcsine angle out of range");
`endif

endmodule

// ===== test/haversine_distance_test.sv =====
// Self-checking testbench for the haversine distance block: directed and random point pairs and radius settings.
module haversine_distance_test;
  import hd_pkg::*;

  localparam int LATENCY = 2 * HD_CORDIC_STAGES + 45;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [30:0] in_first_lat;
  logic [31:0] in_first_lon;
  logic [30:0] in_second_lat;
  logic [31:0] in_second_lon;
  logic        out_valid;
  logic        out_ready;
  logic [25:0] out_distance_m;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Radius as the block should hold it, and the distances still owed by the block
  logic [23:0] radius_now;
  logic [25:0] distances_owed[$];
  int          failures;
  bit          idle_on;   // random idling on both sides
  int          stall_left = 0;

  haversine_distance DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_first_lat(in_first_lat), .in_first_lon(in_first_lon),
    .in_second_lat(in_second_lat), .in_second_lon(in_second_lon),
    .out_valid(out_valid), .out_ready(out_ready), .out_distance_m(out_distance_m),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // ---------------------------------------------------------------------------
  // Predictor: haversine distance in the block's fixed-point formats
  // ---------------------------------------------------------------------------

  // Coordinate in 1e-7 degree to a 32-bit half binary angle, rounded half away from zero
  function automatic logic [31:0] half_angle(input longint coord);
    logic [63:0] mag;
    logic [63:0] q;
    mag = coord < 0 ? 64'(-coord) : 64'(coord);
    q = ((mag << 31) + 64'd1800000000) / 64'd3600000000;
    if (coord < 0) q = -q;
    return q[31:0];
  endfunction

  function automatic longint atan_step(input int i);
    return longint'(HD_CORDIC_X0 - HD_CORDIC_X0) + longint'(hd_atan(i));
  endfunction

  // Rotation-mode CORDIC; >>> on longint rounds towards minus infinity
  task automatic rotate(input logic [31:0] theta, output longint sn, output longint cs);
    logic [1:0] quad;
    bit         flip;
    longint     x, y, z, dx, dy;
    quad = theta[31:30];
    flip = (quad == 2'd1) || (quad == 2'd2);
    x = 64'sd652032874;
    y = 0;
    if (flip) theta = theta + 32'h8000_0000;
    z = longint'($signed(theta));
    for (int i = 0; i < HD_CORDIC_STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  function automatic longint vector_angle(input longint x, input longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < HD_CORDIC_STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic predict_distance(input logic [30:0] lat1_u, input logic [31:0] lon1_u,
                                  input logic [30:0] lat2_u, input logic [31:0] lon2_u,
                                  output logic [25:0] dist_m);
    logic [31:0] a_lat1, a_lon1, a_lat2, a_lon2;
    longint      s1, s2, c1, c2, spare, u, v, h, z;
    logic [63:0] r, c, rad, d;
    a_lat1 = half_angle(longint'($signed(lat1_u)));
    a_lon1 = half_angle(longint'($signed(lon1_u)));
    a_lat2 = half_angle(longint'($signed(lat2_u)));
    a_lon2 = half_angle(longint'($signed(lon2_u)));
    rotate(a_lat2 - a_lat1, s1, spare);
    rotate(a_lon2 - a_lon1, s2, spare);
    rotate(a_lat1 << 1, spare, c1);
    rotate(a_lat2 << 1, spare, c2);
    u = (c1 * s2) >>> 30;
    v = (c2 * s2) >>> 30;
    h = s1 * s1 + u * v;
    // clamp h to [0, one] before the square roots
    if (h < 0) h = 0;
    if (h > longint'(HD_ONE_Q60)) h = longint'(HD_ONE_Q60);
    r = floor_sqrt(64'(h));
    c = floor_sqrt(64'(HD_ONE_Q60) - 64'(h));
    z = vector_angle(longint'(c), longint'(r));
    if (z < 0) z = 0;
    if (z > longint'(HD_ONE_Q30)) z = longint'(HD_ONE_Q30);
    rad = (64'(z) * 64'(HD_HALF_PI_Q30) + (64'd1 << 29)) >> 30;
    d = (64'd2 * 64'(radius_now) * rad + (64'd1 << 29)) >> 30;
    if (d > 64'(HD_DIST_MAX)) d = 64'(HD_DIST_MAX);
    dist_m = d[25:0];
  endtask

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  task automatic idle_burst();
    repeat ($urandom_range(13, 1)) @(posedge clk);
  endtask

  // Send one beat, hold until accepted and record the distance owed for it
  task automatic send_points(input logic [30:0] lat1, input logic [31:0] lon1,
                             input logic [30:0] lat2, input logic [31:0] lon2);
    logic [25:0] dist_m;
    if (idle_on && $urandom_range(3, 0) == 0) begin
      in_valid <= 1'b0;
      idle_burst();
    end
    predict_distance(lat1, lon1, lat2, lon2, dist_m);
    in_valid      <= 1'b1;
    in_first_lat  <= lat1;
    in_first_lon  <= lon1;
    in_second_lat <= lat2;
    in_second_lon <= lon2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    distances_owed = {distances_owed, dist_m};
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain the pipeline, then allow its full depth for anything in flight
  task automatic wait_drained();
    drop_valid();
    while (distances_owed.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_radius(input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {HD_REG_RADIUS, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    radius_now = value[23:0];
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (distances_owed.size() == 0) begin
        $display("%0t: unexpected distance beat, expected none, actual %0d",
                 $time, out_distance_m);
        failures++;
      end else begin
        if (out_distance_m !== distances_owed[0]) begin
          $display("%0t: distance_m mismatch, expected %0d, actual %0d",
                   $time, distances_owed[0], out_distance_m);
          failures++;
        end
        void'(distances_owed.pop_front());
      end
    end
  end

  // Receiver stalls in random bursts while idling is on
  always @(posedge clk) begin
    if (idle_on && stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (idle_on && $urandom_range(5, 0) == 0) begin
      stall_left <= $urandom_range(13, 1);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [30:0] any_lat();
    case ($urandom_range(3, 0))
      0:       return 31'($urandom);   // anything the field holds
      default: return 31'($signed($urandom_range(1800000000, 0)) - 900000000);
    endcase
  endfunction

  function automatic logic [31:0] any_lon();
    case ($urandom_range(3, 0))
      0:       return $urandom;
      default: return 32'($signed(32'($urandom_range(3600000000, 0)) - 32'd1800000000));
    endcase
  endfunction

  // Second point near the first: short distances exercise small h
  function automatic logic [31:0] near(input logic [31:0] v, input int span);
    return v + 32'($signed($urandom_range(2 * span, 0)) - span);
  endfunction

  task automatic send_random(input int count);
    logic [30:0] lat1;
    logic [31:0] lon1;
    for (int n = 0; n < count; n++) begin
      lat1 = any_lat();
      lon1 = any_lon();
      if ($urandom_range(3, 0) == 0)
        send_points(lat1, lon1, 31'(near({1'b0, lat1}, $urandom_range(100000, 1))),
                    near(lon1, $urandom_range(100000, 1)));
      else
        send_points(lat1, lon1, any_lat(), any_lon());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, poles, antipodes, wrap-around and equal points
  task automatic test_directed();
    send_points(31'd0, 32'd0, 31'd0, 32'd0);
    send_points(31'sd900000000, 32'd0, -31'sd900000000, 32'd0);
    send_points(31'd0, 32'd0, 31'd0, 32'sd1800000000);
    send_points(31'd0, -32'sd1800000000, 31'd0, 32'sd1800000000);
    send_points(31'sd900000000, 32'sd1800000000, 31'sd900000000, -32'sd1800000000);
    send_points(31'h3FFF_FFFF, 32'h7FFF_FFFF, 31'h4000_0000, 32'h8000_0000);
    send_points(31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h0000_0001, 32'h0000_0001);
    send_points(31'h4000_0000, 32'h8000_0000, 31'h3FFF_FFFF, 32'h7FFF_FFFF);
    send_points(31'd0, 32'd0, 31'd1, 32'd1);
    send_points(31'sd515000000, -32'sd1200000, 31'sd488500000, 32'sd23500000);
    send_points(31'sd1000000000, 32'd0, -31'sd1000000000, 32'sd900000000);
    send_points(-31'sd450000000, 32'sd2000000000, 31'sd450000000, -32'sd2000000000);
    send_points(31'sd899999999, 32'd0, 31'sd900000000, 32'sd1);
    send_points(31'd0, 32'sd900000000, 31'd0, -32'sd900000000);
  endtask

  task automatic test_radius_extremes();
    logic [31:0] settings[4] = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd16777215};
    foreach (settings[k]) begin
      wait_drained();
      write_radius(settings[k]);
      send_points(31'd0, 32'd0, 31'd0, 32'sd1800000000);
      send_points(31'sd900000000, 32'd0, 31'd0, 32'd0);
      send_random(30);
    end
  endtask

  task automatic test_random_radii();
    for (int k = 0; k < 6; k++) begin
      wait_drained();
      write_radius($urandom);
      send_random(175);
    end
    wait_drained();
    write_radius(32'(HD_RADIUS_RESET));
    send_random(300);
  endtask

  // Full rate with no idling to the end of the run
  task automatic test_full_rate();
    idle_on = 1'b0;
    send_random(200);
    drop_valid();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    failures      = 0;
    idle_on       = 1'b1;
    radius_now    = HD_RADIUS_RESET;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_first_lat  <= '0;
    in_first_lon  <= '0;
    in_second_lat <= '0;
    in_second_lon <= '0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    send_random(60);
    test_radius_extremes();
    test_random_radii();
    test_full_rate();

    while (distances_owed.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: slowest correct run is far below this
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
